// ----- hdl/rft_pkg.sv -----
// rft_pkg: shared types and constants of the restart flap tracker
// holds the search token, result and configuration structs and the command codes
// no dependencies
package rft_pkg;

  localparam int unsigned KEY_W    = 48;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned RUN_W    = 32;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // command codes of an input item
  localparam logic CMD_HEARTBEAT = 1'b0;
  localparam logic CMD_RESET     = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_UNSTABLE = CFG_IDX_W'(1);

  // register reset values
  localparam logic [RUN_W-1:0]   MIN_RUN_RST      = RUN_W'(30000);
  localparam logic [COUNT_W-1:0] MAX_UNSTABLE_RST = COUNT_W'(5);

  typedef struct packed {
    logic [RUN_W-1:0]   min_run_ms;
    logic [COUNT_W-1:0] max_unstable;
  } cfg_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              cmd;
    logic [KEY_W-1:0]  node_id;
    logic [TIME_W-1:0] start_ms;
    logic [TIME_W-1:0] now_ms;
    logic              done;
    logic              allowed;
    logic              found;
  } token_t;

  typedef struct packed {
    logic allowed;
    logic found;
    logic table_full;
  } res_t;

endpackage

// ----- hdl/restart_flap_tracker.sv -----
// restart_flap_tracker: top level of the restart flap tracker
// a row of rft_cell entries searched by a travelling token, with an rft_out_queue on the result side
// depends on rft_pkg, rft_cell and rft_out_queue
//
// Usage:
//   in_*  : one item per transfer (cmd, node_id, start_ms, now_ms). cmd heartbeat
//           looks up, updates or adds the node; cmd reset clears a known node's count.
//   out_* : one result per item (allowed, found, table_full), in input order.
//   cfg_* : register writes (index 0 min_run_ms, 1 max_unstable), always ready;
//           other indexes are ignored. Write only while the block is idle.
// Path: an accepted item walks the cell chain one entry per cycle; its result is
//   registered into the result queue from the end of the chain and drives out_valid.
// Ordering: one item is in the chain at a time; the next item is taken only once
//   the result of the last has left the cell chain.
// Reset: rst_n (synchronous, low) empties the table, the chain and the result queue
//   and loads min_run_ms = 30000, max_unstable = 5.
// Stall: a two-entry result queue holds results while out_ready is low; the next
//   item is still taken while one result waits, and in_ready drops when both
//   entries are taken.
module restart_flap_tracker #(
  parameter int unsigned NODE_ENTRIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic [rft_pkg::KEY_W-1:0]       in_node_id,
  input  logic [rft_pkg::TIME_W-1:0]      in_start_ms,
  input  logic [rft_pkg::TIME_W-1:0]      in_now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_allowed,
  output logic                            out_found,
  output logic                            out_table_full,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rft_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rft_pkg::*;

  cfg_t   cfg_r;
  cfg_t   cfg_nxt;
  logic   busy_r;
  logic   busy_nxt;
  logic   in_xfer;
  logic   q_full;
  logic   head_valid;
  res_t   head_data;
  res_t   res;
  token_t chain [NODE_ENTRIES+1];
  token_t tail;
  logic [NODE_ENTRIES-1:0] tok_live;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r && !q_full;
  assign in_xfer   = in_valid && in_ready;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MIN_RUN:      cfg_nxt.min_run_ms   = cfg_wdata;
        CFG_MAX_UNSTABLE: cfg_nxt.max_unstable = cfg_wdata[COUNT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_run_ms   <= MIN_RUN_RST;
      cfg_r.max_unstable <= MAX_UNSTABLE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // token entering the first cell
  always_comb begin
    chain[0].vld      = in_xfer;
    chain[0].cmd      = in_cmd;
    chain[0].node_id  = in_node_id;
    chain[0].start_ms = in_start_ms;
    chain[0].now_ms   = in_now_ms;
    chain[0].done     = 1'b0;
    chain[0].allowed  = 1'b0;
    chain[0].found    = 1'b0;
  end

  // row of table entries
  for (genvar g = 0; g < NODE_ENTRIES; g++) begin : g_cell
    rft_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cfg   (cfg_r),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
    assign tok_live[g] = chain[g+1].vld;
  end

  assign tail = chain[NODE_ENTRIES];

  // an unmatched heartbeat that found no free entry means a full table
  always_comb begin
    res.allowed    = tail.allowed;
    res.found      = tail.found;
    res.table_full = 1'b0;
    if (!tail.done && tail.cmd == CMD_HEARTBEAT) begin
      res.allowed    = 1'b1;
      res.found      = 1'b0;
      res.table_full = 1'b1;
    end
  end

  // one item in the chain at a time
  always_comb begin
    busy_nxt = busy_r;
    if (in_xfer) begin
      busy_nxt = 1'b1;
    end else if (tail.vld) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  rft_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (tail.vld),
    .push_data  (res),
    .pop        (out_ready),
    .head_valid (head_valid),
    .head_data  (head_data),
    .q_full     (q_full)
  );

  assign out_valid      = head_valid;
  assign out_allowed    = head_data.allowed;
  assign out_found      = head_data.found;
  assign out_table_full = head_data.table_full;

  // at most one token travels the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_live))
    else $error("more than one token in the cell chain");

  // a token in the chain means the block is busy
  a_busy_token: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_live != '0) |-> busy_r)
    else $error("token in flight while idle");

  // a result leaves the chain only for an accepted item
  a_tail_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> busy_r)
    else $error("result without an item in flight");

  // found and table_full never both set
  a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> !(res.found && res.table_full))
    else $error("found and table_full both set");

endmodule

// ----- hdl/rft_cell.sv -----
// rft_cell: one table entry of the restart flap tracker and its token stage
// compares the passing token with its entry, applies the restart rules and passes it on
// depends on rft_pkg
module rft_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  rft_pkg::cfg_t   cfg,
  input  rft_pkg::token_t tok_i,
  output rft_pkg::token_t tok_o
);
  import rft_pkg::*;

  logic               e_valid_r;
  logic [KEY_W-1:0]   e_node_r;
  logic [TIME_W-1:0]  e_last_r;
  logic [COUNT_W-1:0] e_cnt_r;

  logic               e_valid_nxt;
  logic [KEY_W-1:0]   e_node_nxt;
  logic [TIME_W-1:0]  e_last_nxt;
  logic [COUNT_W-1:0] e_cnt_nxt;

  token_t tok_r;
  token_t tok_nxt;
  logic   tok_vld_r;

  logic               live;
  logic               hit;
  logic               claim;
  logic [TIME_W-1:0]  thr;
  logic [TIME_W-1:0]  run_len;
  logic [TIME_W-1:0]  gap;
  logic [COUNT_W-1:0] cnt_hb;

  assign live  = tok_i.vld && !tok_i.done;
  assign hit   = live && e_valid_r && (e_node_r == tok_i.node_id);
  assign claim = live && !e_valid_r;
  assign thr   = TIME_W'(cfg.min_run_ms);

  assign run_len = tok_i.now_ms - e_last_r;
  assign gap     = tok_i.start_ms - e_last_r;

  // stable-run, unstable-restart and stale-message rules
  always_comb begin
    cnt_hb = e_cnt_r;
    if (tok_i.start_ms == e_last_r) begin
      if ((tok_i.now_ms >= e_last_r) && (run_len >= thr) && (e_cnt_r != '0)) begin
        cnt_hb = '0;
      end
    end else if (tok_i.start_ms > e_last_r) begin
      if (gap < thr) begin
        if (e_cnt_r != COUNT_MAX) begin
          cnt_hb = e_cnt_r + COUNT_W'(1);
        end
      end else begin
        cnt_hb = '0;
      end
    end
  end

  // entry and token update
  always_comb begin
    e_valid_nxt = e_valid_r;
    e_node_nxt  = e_node_r;
    e_last_nxt  = e_last_r;
    e_cnt_nxt   = e_cnt_r;
    tok_nxt     = tok_i;
    if (hit) begin
      tok_nxt.done  = 1'b1;
      tok_nxt.found = 1'b1;
      if (tok_i.cmd == CMD_RESET) begin
        e_cnt_nxt       = '0;
        tok_nxt.allowed = 1'b0;
      end else begin
        e_cnt_nxt       = cnt_hb;
        tok_nxt.allowed = (cnt_hb < cfg.max_unstable);
        if (tok_i.start_ms > e_last_r) begin
          e_last_nxt = tok_i.start_ms;
        end
      end
    end else if (claim) begin
      // entries fill from the bottom, so a free entry ends the search
      tok_nxt.done  = 1'b1;
      tok_nxt.found = 1'b0;
      if (tok_i.cmd == CMD_HEARTBEAT) begin
        e_valid_nxt     = 1'b1;
        e_node_nxt      = tok_i.node_id;
        e_last_nxt      = tok_i.start_ms;
        e_cnt_nxt       = '0;
        tok_nxt.allowed = 1'b1;
      end else begin
        tok_nxt.allowed = 1'b0;
      end
    end
  end

  // valid bit and token valid under reset, payload without
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      e_valid_r <= e_valid_nxt;
      tok_vld_r <= tok_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    e_node_r <= e_node_nxt;
    e_last_r <= e_last_nxt;
    e_cnt_r  <= e_cnt_nxt;
    tok_r    <= tok_nxt;
  end

  // outgoing token takes its valid from the reset register
  always_comb begin
    tok_o     = tok_r;
    tok_o.vld = tok_vld_r;
  end

  // a matching entry is always a valid one
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> e_valid_r)
    else $error("match on an empty entry");

  // a claimed entry is valid afterwards and holds the key
  a_claim_store: assert property (@(posedge clk) disable iff (!rst_n)
    (claim && tok_i.cmd == CMD_HEARTBEAT) |=> (e_valid_r && e_node_r == $past(tok_i.node_id)))
    else $error("new node not stored");

  // a valid entry never becomes invalid
  a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    e_valid_r |=> e_valid_r)
    else $error("entry lost");

endmodule

// ----- hdl/rft_out_queue.sv -----
// rft_out_queue: two-entry result queue of the restart flap tracker
// decouples the end of the cell chain from a stalled receiver
// depends on rft_pkg
module rft_out_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rft_pkg::res_t push_data,
  input  logic          pop,
  output logic          head_valid,
  output rft_pkg::res_t head_data,
  output logic          q_full
);
  import rft_pkg::*;

  res_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  logic       wr_ptr_nxt;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_nxt;
  logic       do_pop;

  assign head_valid = (cnt_r != 2'd0);
  assign head_data  = slot_r[rd_ptr_r];
  assign q_full     = (cnt_r == 2'd2);
  assign do_pop     = pop && head_valid;

  // pointer and level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // no transfer into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("result queue overflow");

  // level stays within the two entries
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue level out of range");

  // pointers agree with the level
  a_ptr_level: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with level");

endmodule

// ----- bench/restart_flap_tracker_tb.sv -----
// restart_flap_tracker_tb: self-checking bench for the restart flap tracker
// drives heartbeat and reset transfers, predicts every verdict and checks the results in order
// depends on rft_pkg and restart_flap_tracker
`timescale 1ns / 1ps

module restart_flap_tracker_tb;
  import rft_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int POOL        = 48;
  localparam int LONG_HOLD   = 600;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(15);

  typedef struct {
    logic              cmd;
    logic [KEY_W-1:0]  node_id;
    logic [TIME_W-1:0] start_ms;
    logic [TIME_W-1:0] now_ms;
    int                gap;
  } beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_cmd = CMD_HEARTBEAT;
  logic [KEY_W-1:0]      in_node_id = '0;
  logic [TIME_W-1:0]     in_start_ms = '0;
  logic [TIME_W-1:0]     in_now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_allowed;
  logic                  out_found;
  logic                  out_table_full;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  restart_flap_tracker #(.NODE_ENTRIES(TABLE_DEPTH)) dut (.*);

  // predicted table and register copies
  logic              tbl_used  [TABLE_DEPTH];
  logic [KEY_W-1:0]  tbl_key   [TABLE_DEPTH];
  logic [TIME_W-1:0] tbl_start [TABLE_DEPTH];
  logic [COUNT_W-1:0] tbl_count [TABLE_DEPTH];
  logic [RUN_W-1:0]   run_min = MIN_RUN_RST;
  logic [COUNT_W-1:0] unstable_cap = MAX_UNSTABLE_RST;
  int                 peak_count = 0;

  beat_t pending_beats[$];
  res_t  expected_verdicts[$];

  // stimulus-side view of the node pool
  logic [KEY_W-1:0]  pool_key   [POOL];
  logic [TIME_W-1:0] pool_start [POOL];
  bit                pool_known [POOL];
  int                pool_live = 0;
  int                stored_nodes = 0;

  bit src_lazy = 1'b1;
  bit sink_lazy = 1'b1;
  bit hold_req = 1'b0;
  bit hold_taken;
  int hold_left;
  bit item_held = 1'b0;

  int fail_count = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int refused_seen = 0;
  int full_seen = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  // verdict for one transfer; updates the predicted table
  function automatic res_t track_node(input beat_t b);
    int slot;
    int vacant;
    logic [TIME_W-1:0] last;
    logic [COUNT_W-1:0] cnt;
    res_t r;
    r = '0;
    slot = -1;
    vacant = -1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot < 0 && tbl_used[i] && tbl_key[i] == b.node_id) slot = i;
      if (vacant < 0 && !tbl_used[i]) vacant = i;
    end
    if (b.cmd == CMD_RESET) begin
      if (slot >= 0) begin
        tbl_count[slot] = '0;
        r.found = 1'b1;
      end
    end else if (slot < 0) begin
      r.allowed = 1'b1;
      if (vacant >= 0) begin
        tbl_used[vacant] = 1'b1;
        tbl_key[vacant] = b.node_id;
        tbl_start[vacant] = b.start_ms;
        tbl_count[vacant] = '0;
      end else begin
        r.table_full = 1'b1;
      end
    end else begin
      last = tbl_start[slot];
      cnt = tbl_count[slot];
      r.found = 1'b1;
      if (b.start_ms == last) begin
        // stable run only once the clock has passed the stored start
        if (b.now_ms >= last && (b.now_ms - last) >= TIME_W'(run_min)) cnt = '0;
      end else if (b.start_ms > last) begin
        if ((b.start_ms - last) < TIME_W'(run_min)) begin
          if (cnt != COUNT_MAX) cnt = cnt + 1'b1;
        end else begin
          cnt = '0;
        end
        tbl_start[slot] = b.start_ms;
      end
      tbl_count[slot] = cnt;
      if (int'(cnt) > peak_count) peak_count = int'(cnt);
      r.allowed = (cnt < unstable_cap);
    end
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_word48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic queue_beat(input logic cmd, input logic [KEY_W-1:0] node,
                            input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] nw);
    beat_t b;
    b.cmd = cmd;
    b.node_id = node;
    b.start_ms = st;
    b.now_ms = nw;
    b.gap = src_lazy ? $urandom_range(0, 6) : 0;
    pending_beats.push_back(b);
  endtask

  // heartbeat on a pool node, keeping the latest start in view
  task automatic queue_pool_beat(input int k, input logic [TIME_W-1:0] st,
                                 input logic [TIME_W-1:0] nw);
    queue_beat(CMD_HEARTBEAT, pool_key[k], st, nw);
    if (st > pool_start[k]) pool_start[k] = st;
  endtask

  task automatic introduce_node(input int k);
    pool_start[k] = rand_word48();
    pool_known[k] = 1'b1;
    stored_nodes++;
    queue_pool_beat(k, pool_start[k], pool_start[k] + TIME_W'($urandom_range(0, 5000)));
  endtask

  task automatic queue_restart(input int k, input logic [TIME_W-1:0] delta);
    logic [TIME_W-1:0] st;
    st = pool_start[k] + delta;
    queue_pool_beat(k, st, st + TIME_W'($urandom_range(0, 5000)));
  endtask

  // one random transfer, mostly well-formed sequences around the thresholds
  task automatic queue_random_beat(input int lo);
    int k;
    int pick;
    logic [TIME_W-1:0] thr;
    logic [TIME_W-1:0] st;
    logic [TIME_W-1:0] nw;
    logic [TIME_W-1:0] delta;
    k = $urandom_range(lo, pool_live - 1);
    pick = $urandom_range(0, 99);
    thr = TIME_W'(run_min);
    st = pool_start[k];
    if (!pool_known[k]) begin
      if (pick < 70) introduce_node(k);
      else queue_beat(CMD_RESET, pool_key[k], rand_word48(), rand_word48());
    end else if (pick < 5) begin
      // noise: arbitrary times
      queue_pool_beat(k, rand_word48(), rand_word48());
    end else if (pick < 30) begin
      // same start, clock around the stable-run threshold
      case ($urandom_range(0, 4))
        0: nw = st + thr;
        1: nw = (thr == 0) ? st : st + thr - 1'b1;
        2: nw = st + thr + TIME_W'($urandom_range(1, 5000));
        3: nw = st + TIME_W'($urandom_range(0, (run_min == 0) ? 0 : run_min - 1));
        default: nw = st - TIME_W'($urandom_range(1, 5000));
      endcase
      queue_pool_beat(k, st, nw);
    end else if (pick < 62) begin
      // restart with a gap around the threshold
      case ($urandom_range(0, 5))
        0: delta = 1;
        1: delta = (thr > 1) ? thr - 1'b1 : TIME_W'(1);
        2: delta = thr;
        3: delta = thr + TIME_W'($urandom_range(1, 5000));
        4: delta = TIME_W'($urandom_range(1, (run_min > 1) ? run_min - 1 : 1));
        default: delta = TIME_W'($urandom) << $urandom_range(0, 15);
      endcase
      queue_restart(k, delta);
    end else if (pick < 74) begin
      // stale message from an older process
      queue_pool_beat(k, st - TIME_W'($urandom_range(1, 50000)),
                      st + TIME_W'($urandom_range(0, 50000)));
    end else if (pick < 88) begin
      queue_beat(CMD_RESET, pool_key[k], rand_word48(), rand_word48());
    end else begin
      queue_beat(CMD_RESET, rand_word48(), rand_word48(), rand_word48());
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MIN_RUN) run_min = val;
    else if (idx == CFG_MAX_UNSTABLE) unstable_cap = val[COUNT_W-1:0];
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || item_held || expected_verdicts.size() != 0);
  endtask

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // input driver: one transfer per pending item, gap drawn per item
  beat_t cur_beat;
  int    wait_left = 0;
  bit    offer;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      item_held = 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(track_node(cur_beat));
        accepted_count++;
        offer = 1'b0;
        item_held = 1'b0;
      end
      if (!item_held && pending_beats.size() != 0) begin
        cur_beat = pending_beats.pop_front();
        item_held = 1'b1;
        wait_left = cur_beat.gap;
      end
      if (item_held && !offer) begin
        if (wait_left != 0) begin
          wait_left--;
        end else begin
          offer = 1'b1;
          in_cmd <= cur_beat.cmd;
          in_node_id <= cur_beat.node_id;
          in_start_ms <= cur_beat.start_ms;
          in_now_ms <= cur_beat.now_ms;
        end
      end
      in_valid <= offer;
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_left <= LONG_HOLD;
      hold_taken <= 1'b1;
    end
  end

  // result monitor: compares each transfer with the oldest verdict
  res_t got;
  res_t want;
  int   sink_wait = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.allowed = out_allowed;
        got.found = out_found;
        got.table_full = out_table_full;
        results_seen++;
        if (got.found && !got.allowed) refused_seen++;
        if (got.table_full) full_seen++;
        if (expected_verdicts.size() == 0) begin
          $error("result transfer with no verdict outstanding");
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got.allowed !== want.allowed) begin
            $error("allowed: expected %0b, got %0b", want.allowed, got.allowed);
            fail_count++;
          end
          if (got.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, got.found);
            fail_count++;
          end
          if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0b, got %0b", want.table_full, got.table_full);
            fail_count++;
          end
        end
        sink_wait = sink_lazy ? $urandom_range(0, 6) : 0;
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      out_ready <= (sink_wait == 0) && (hold_left == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
               expected_verdicts.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus sequence
  logic [TIME_W-1:0] t;
  int fill;
  bit clash;

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) tbl_used[i] = 1'b0;
    // distinct pool keys, away from the directed all-zero and all-one keys
    for (int i = 0; i < POOL; i++) begin
      do begin
        pool_key[i] = rand_word48();
        clash = (pool_key[i] == '0) || (pool_key[i] == '1);
        for (int j = 0; j < i; j++) if (pool_key[j] == pool_key[i]) clash = 1'b1;
      end while (clash);
      pool_known[i] = 1'b0;
      pool_start[i] = '0;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed checks at the reset register values
    queue_beat(CMD_RESET, '0, '1, '1);
    queue_beat(CMD_HEARTBEAT, '0, '0, '0);
    queue_beat(CMD_HEARTBEAT, '0, '0, TIME_W'(29999));
    queue_beat(CMD_HEARTBEAT, '1, '1, '1);
    queue_beat(CMD_HEARTBEAT, '1, '1, '0);
    t = '0;
    // fast restarts up to and past the refusal count
    for (int i = 0; i < 6; i++) begin
      t = t + TIME_W'(29999);
      queue_beat(CMD_HEARTBEAT, '0, t, t);
    end
    queue_beat(CMD_HEARTBEAT, '0, t, t + TIME_W'(29999));
    queue_beat(CMD_HEARTBEAT, '0, t, t - 1'b1);
    queue_beat(CMD_HEARTBEAT, '0, t - TIME_W'(1000), t + TIME_W'(50000));
    queue_beat(CMD_HEARTBEAT, '0, t, t + TIME_W'(30000));
    t = t + TIME_W'(30000);
    queue_beat(CMD_HEARTBEAT, '0, t, t);
    queue_beat(CMD_HEARTBEAT, '0, t + 1'b1, t + 1'b1);
    queue_beat(CMD_RESET, '0, '0, '0);
    queue_beat(CMD_HEARTBEAT, '0, '1, '1);
    queue_beat(CMD_RESET, '1, '1, '1);
    stored_nodes = 2;
    wait_idle();

    // short threshold, low limit, upper data bits masked, unused index ignored
    write_reg(CFG_MIN_RUN, 32'd1000);
    write_reg(CFG_MAX_UNSTABLE, 32'hFFFF_FF03);
    write_reg(CFG_UNUSED, $urandom());
    pool_live = POOL;
    for (int k = 0; k < 4; k++) introduce_node(k);
    for (int i = 0; i < 30; i++) queue_random_beat(0);
    wait_idle();

    // zero threshold and zero limit, no idling on either side
    write_reg(CFG_MIN_RUN, '0);
    write_reg(CFG_MAX_UNSTABLE, '0);
    src_lazy = 1'b0;
    sink_lazy = 1'b0;
    for (int i = 0; i < 30; i++) queue_random_beat(0);
    wait_idle();

    // receiver holds off while the sender keeps offering
    write_reg(CFG_MIN_RUN, 32'd30000);
    write_reg(CFG_MAX_UNSTABLE, 32'd5);
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) queue_random_beat(0);
    src_lazy = 1'b1;
    sink_lazy = 1'b1;
    for (int i = 0; i < 30; i++) queue_random_beat(0);
    wait_idle();

    // widest threshold, top limit: one node flaps until its count saturates
    write_reg(CFG_MIN_RUN, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_UNSTABLE, 32'd255);
    for (int i = 0; i < 262; i++) begin
      src_lazy = (i % 64) < 40;
      queue_restart(0, TIME_W'($urandom_range(1, 4096)));
      if ($urandom_range(0, 11) == 0) queue_random_beat(1);
    end
    src_lazy = 1'b1;
    wait_idle();

    // random registers, then the table is filled and overflowed
    write_reg(CFG_MIN_RUN, $urandom());
    write_reg(CFG_MAX_UNSTABLE, $urandom());
    for (int i = 0; i < 20; i++) queue_random_beat(0);
    for (int k = 0; k < POOL; k++) if (!pool_known[k]) introduce_node(k);
    fill = TABLE_DEPTH - stored_nodes + 5;
    for (int i = 0; i < fill; i++)
      queue_beat(CMD_HEARTBEAT, rand_word48(), rand_word48(), rand_word48());
    stored_nodes = TABLE_DEPTH;
    for (int i = 0; i < 20; i++) queue_random_beat(0);
    wait_idle();

    repeat (2 * (TABLE_DEPTH + 1)) @(posedge clk);
    $display("%0d items in, %0d results checked, %0d refusals, %0d table-full flags",
             accepted_count, results_seen, refused_seen, full_seen);
    $display("peak restart count %0d, %0d register writes", peak_count, cfg_writes);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
